// File: rtl/core/round_robin_thread_scheduler_macros.svh
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_MACROS_SVH

// same-cycle implication, checked outside reset
`define RRTS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RRTS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// condition that must never hold
`define RRTS_ASSERT_NEVER(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) 1'b1 |-> !(expr)) \
        else $error(msg);

`endif

// File: rtl/core/rrts_pkg.sv
package rrts_pkg;

    // thread ids on the ports are 4 bits wide
    localparam int ID_SPAN   = 16;
    localparam int MAIN_PRIO = 31;

    typedef enum logic [1:0] {
        K_CREATE  = 2'd0,
        K_YIELD   = 2'd1,
        K_BLOCK   = 2'd2,
        K_UNBLOCK = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        TS_UNUSED  = 3'd0,
        TS_RUNNING = 3'd1,
        TS_READY   = 3'd2,
        TS_BLOCKED = 3'd3,
        TS_WAITING = 3'd4,
        TS_HANDING = 3'd5
    } t_tst;

    typedef enum logic [1:0] {
        ERR_OK          = 2'd0,
        ERR_EMPTY       = 2'd1,
        ERR_NOT_BLOCKED = 2'd2,
        ERR_IN_USE      = 2'd3
    } t_err;

    localparam logic [1:0] RSN_BLOCKED = 2'd0;
    localparam logic [1:0] RSN_WAITING = 2'd1;
    localparam logic [1:0] RSN_HANDING = 2'd2;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic load;   // capture the input transfer
        logic exec;   // update tables and load the result register
    } t_dp_cmd;

    typedef struct packed {
        logic q_full;
    } t_dp_stat;

endpackage

// File: rtl/core/rrts_ctrl.sv
`include "round_robin_thread_scheduler_macros.svh"

module rrts_ctrl import rrts_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_valid,
    output logic     o_s_ready,
    output logic     o_m_valid,
    input  logic     i_m_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;
    logic   s_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_m_valid  = r_m_valid;
        // result register must be free by the time the item executes
        s_ready    = 1'b0;
        o_cmd      = '0;
        if (r_m_valid && i_m_ready) begin
            n_m_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                s_ready = !r_m_valid || i_m_ready;
                if (s_ready && i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_m_valid  = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_s_ready = s_ready;
    assign o_m_valid = r_m_valid;

    `RRTS_ASSERT_IMP(a_exec_slot_free, i_clk, i_rst_n, o_cmd.exec, !r_m_valid, "exec with result pending")
    `RRTS_ASSERT_NXT(a_load_then_exec, i_clk, i_rst_n, o_cmd.load, o_cmd.exec, "load not followed by exec")
    `RRTS_ASSERT_NEVER(a_queue_never_full, i_clk, i_rst_n, i_stat.q_full, "ready queue overfilled")

endmodule

// File: rtl/core/rrts_dp.sv
`include "round_robin_thread_scheduler_macros.svh"

module rrts_dp import rrts_pkg::*; #(
    parameter int MAX_THREADS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_stat   o_stat,
    input  logic [1:0] i_kind,
    input  logic [3:0] i_thread_id,
    input  logic [7:0] i_priority_req,
    input  logic [1:0] i_block_reason,
    output logic [3:0] o_running_id,
    output logic       o_switched,
    output logic [3:0] o_requeued_id,
    output logic [7:0] o_refill_ticks,
    output logic [1:0] o_error
);

    // ids beyond the port range can never be created, so no storage for them
    localparam int NTHR = (MAX_THREADS < ID_SPAN) ? MAX_THREADS : ID_SPAN;
    localparam int TW   = $clog2(NTHR);
    localparam int CW   = $clog2(NTHR + 1);
    localparam int SW   = CW + 1;
    localparam logic [TW-1:0] LAST    = TW'(NTHR - 1);
    localparam logic [3:0]    TID_MAX = 4'(NTHR - 1);
    localparam logic [SW-1:0] DEPTH_S = SW'(NTHR);
    localparam logic [CW-1:0] DEPTH_C = CW'(NTHR);
    localparam logic [CW-1:0] CNT_MAX = CW'(NTHR - 1);

    // captured item
    t_kind       r_kind;
    logic [3:0]  r_tid;
    logic [7:0]  r_prio;
    logic [1:0]  r_reason;

    // thread tables and ready deque
    t_tst        r_status   [NTHR];
    logic [7:0]  r_prio_tab [NTHR];
    logic [TW-1:0] r_queue  [NTHR];
    logic [TW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [TW-1:0] r_run, n_run;

    // result register
    logic [3:0]  r_o_run;
    logic        r_switched, n_switched;
    logic [3:0]  r_requeued;
    logic [7:0]  r_refill, n_refill;
    t_err        r_error, n_error;

    logic          tid_ok;
    logic [TW-1:0] tidx;
    t_tst          st_t;
    logic          q_empty;
    logic [TW-1:0] head_inc, head_dec, tail, q_head_id;
    logic [SW-1:0] tail_sum, tail_wrap;

    logic          q_we;
    logic [TW-1:0] q_waddr, q_wdata;
    logic          st_we_a, st_we_b, pr_we;
    logic [TW-1:0] st_a_addr, st_b_addr;
    t_tst          st_a_val;

    assign tid_ok    = r_tid <= TID_MAX;
    assign tidx      = r_tid[TW-1:0];
    assign st_t      = r_status[tidx];
    assign q_empty   = r_count == '0;
    assign q_head_id = r_queue[r_head];
    assign head_inc  = (r_head == LAST) ? '0 : r_head + 1'b1;
    assign head_dec  = (r_head == '0) ? LAST : r_head - 1'b1;
    assign tail_sum  = SW'(r_head) + SW'(r_count);
    assign tail_wrap = (tail_sum >= DEPTH_S) ? tail_sum - DEPTH_S : tail_sum;
    assign tail      = tail_wrap[TW-1:0];

    always_comb begin
        n_head     = r_head;
        n_count    = r_count;
        n_run      = r_run;
        n_switched = 1'b0;
        n_refill   = '0;
        n_error    = ERR_OK;
        q_we       = 1'b0;
        q_waddr    = tail;
        q_wdata    = tidx;
        st_we_a    = 1'b0;
        st_a_addr  = tidx;
        st_a_val   = TS_READY;
        st_we_b    = 1'b0;
        st_b_addr  = q_head_id;
        pr_we      = 1'b0;
        case (r_kind)
            K_CREATE: begin
                if (!tid_ok || st_t != TS_UNUSED) begin
                    n_error = ERR_IN_USE;
                end else begin
                    st_we_a = 1'b1;
                    pr_we   = 1'b1;
                    q_we    = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            K_YIELD: begin
                n_switched = 1'b1;
                n_refill   = r_prio_tab[r_run];
                // alone in the system: pushed and popped again, nothing moves
                if (!q_empty) begin
                    q_we      = 1'b1;
                    q_wdata   = r_run;
                    n_head    = head_inc;
                    st_we_a   = 1'b1;
                    st_a_addr = r_run;
                    st_we_b   = 1'b1;
                    n_run     = q_head_id;
                end
            end
            K_BLOCK: begin
                case (r_reason)
                    RSN_BLOCKED: st_a_val = TS_BLOCKED;
                    RSN_WAITING: st_a_val = TS_WAITING;
                    RSN_HANDING: st_a_val = TS_HANDING;
                    default:     st_a_val = TS_RUNNING;
                endcase
                if (r_reason == RSN_BLOCKED || r_reason == RSN_WAITING ||
                    r_reason == RSN_HANDING) begin
                    if (q_empty) begin
                        n_error = ERR_EMPTY;
                    end else begin
                        st_we_a    = 1'b1;
                        st_a_addr  = r_run;
                        st_we_b    = 1'b1;
                        n_run      = q_head_id;
                        n_head     = head_inc;
                        n_count    = r_count - 1'b1;
                        n_switched = 1'b1;
                    end
                end
            end
            K_UNBLOCK: begin
                if (tid_ok && (st_t == TS_BLOCKED || st_t == TS_WAITING ||
                               st_t == TS_HANDING)) begin
                    n_head  = head_dec;
                    q_we    = 1'b1;
                    q_waddr = head_dec;
                    n_count = r_count + 1'b1;
                    st_we_a = 1'b1;
                end else begin
                    n_error = ERR_NOT_BLOCKED;
                end
            end
            default: begin
                n_error = ERR_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= t_kind'(i_kind);
            r_tid    <= i_thread_id;
            r_prio   <= i_priority_req;
            r_reason <= i_block_reason;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NTHR; i++) begin
                r_status[i]   <= (i == 0) ? TS_RUNNING : TS_UNUSED;
                r_prio_tab[i] <= (i == 0) ? 8'(MAIN_PRIO) : 8'd0;
            end
            r_head  <= '0;
            r_count <= '0;
            r_run   <= '0;
        end else if (i_cmd.exec) begin
            if (st_we_a) begin
                r_status[st_a_addr] <= st_a_val;
            end
            if (st_we_b) begin
                r_status[st_b_addr] <= TS_RUNNING;
            end
            if (pr_we) begin
                r_prio_tab[tidx] <= r_prio;
            end
            r_head  <= n_head;
            r_count <= n_count;
            r_run   <= n_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && q_we) begin
            r_queue[q_waddr] <= q_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_o_run    <= 4'(n_run);
            r_switched <= n_switched;
            r_requeued <= 4'(r_run);
            r_refill   <= n_refill;
            r_error    <= n_error;
        end
    end

    assign o_stat.q_full  = r_count == DEPTH_C;
    assign o_running_id   = r_o_run;
    assign o_switched     = r_switched;
    assign o_requeued_id  = r_requeued;
    assign o_refill_ticks = r_refill;
    assign o_error        = r_error;

    `RRTS_ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CNT_MAX, "queue holds running thread")
    `RRTS_ASSERT_IMP(a_run_status, i_clk, i_rst_n, 1'b1, r_status[r_run] == TS_RUNNING, "running thread not marked running")
    `RRTS_ASSERT_NXT(a_err_no_change, i_clk, i_rst_n, i_cmd.exec && n_error != ERR_OK, r_run == $past(r_run) && r_count == $past(r_count), "failed item changed state")

endmodule

// File: rtl/core/round_robin_thread_scheduler.sv
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tuser: kind[1:0]
//                tdata: thread_id[3:0] priority_req[11:4] block_reason[13:12], zero fill [15:14]
// m_axis    out  tdata: running_id[3:0] switched[4] requeued_id[8:5] refill_ticks[16:9]
//                error[18:17], zero fill [23:19]
//
// Each event is captured, then applied as one table and deque update; s_axis is not ready meanwhile.
// A result sits in an output register; the next event is taken in the cycle that
// register drains, so a stalled m_axis holds off s_axis after one event.
// Reset (sync, active low) makes thread 0 running at priority 31, queue empty.

module round_robin_thread_scheduler import rrts_pkg::*; #(
    parameter int MAX_THREADS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [1:0]  i_s_axis_tuser,  // kind
    input  logic [15:0] i_s_axis_tdata,  // thread_id, priority_req, block_reason
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata   // running_id, switched, requeued_id, refill_ticks, error
);

    t_dp_cmd    cmd;
    t_dp_stat   stat;
    logic [3:0] running_id;
    logic       switched;
    logic [3:0] requeued_id;
    logic [7:0] refill_ticks;
    logic [1:0] error_code;

    rrts_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_cmd     (cmd),
        .i_stat    (stat)
    );

    rrts_dp #(
        .MAX_THREADS (MAX_THREADS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_kind         (i_s_axis_tuser),
        .i_thread_id    (i_s_axis_tdata[3:0]),
        .i_priority_req (i_s_axis_tdata[11:4]),
        .i_block_reason (i_s_axis_tdata[13:12]),
        .o_running_id   (running_id),
        .o_switched     (switched),
        .o_requeued_id  (requeued_id),
        .o_refill_ticks (refill_ticks),
        .o_error        (error_code)
    );

    assign o_m_axis_tdata = {5'd0, error_code, refill_ticks, requeued_id, switched, running_id};

endmodule
